/* rtl/gbn_pkg.sv */
// shared types and constants for the greedy box nms core
package gbn_pkg;

  // field widths of a box and its derived values
  localparam int COORD_W  = 16;
  localparam int DIM_W    = 15;
  localparam int AREA_W   = 2 * DIM_W;
  localparam int EDGE_W   = COORD_W + 1;
  localparam int THR_W    = 9;
  localparam int IDX_W    = 16;
  localparam int KEPT_W   = 7;
  localparam int UNI_W    = AREA_W + 1;
  localparam int PROD_W   = THR_W + UNI_W;
  localparam int FRAC_SH  = 8;

  // kept store depth and its address width
  localparam int MAX_KEPT = 64;
  localparam int ADDR_W   = $clog2(MAX_KEPT);

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(115);

  // one candidate or kept box
  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic [DIM_W-1:0]          width;
    logic [DIM_W-1:0]          height;
  } gbn_box_t;

  // one entry of the kept store
  typedef struct packed {
    gbn_box_t          box;
    logic [AREA_W-1:0] area;
  } gbn_entry_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } gbn_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic issue_done;
    logic pipe_empty;
    logic out_free;
  } gbn_stat_t;

endpackage

/* rtl/gbn_ctrl.sv */
// controller state machine: accepts a box, sweeps the kept store, emits the result
module gbn_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  gbn_pkg::gbn_stat_t stat,
  output gbn_pkg::gbn_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRAP
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r, in_tready_nxt;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    in_tready_nxt = in_tready_r;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready_r) begin
          cmd.load      = 1'b1;
          state_nxt     = S_SCAN;
          in_tready_nxt = 1'b0;
        end
      end
      S_SCAN: begin
        if (stat.issue_done) begin
          state_nxt = S_WRAP;
        end else begin
          cmd.issue = 1'b1;
        end
      end
      S_WRAP: begin
        if (stat.pipe_empty && stat.out_free) begin
          cmd.finish    = 1'b1;
          state_nxt     = S_IDLE;
          in_tready_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt     = S_IDLE;
        in_tready_nxt = 1'b1;
      end
    endcase
  end

  // state and registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_tready_r <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= in_tready_nxt;
    end
  end

  assign in_tready = in_tready_r;

  // ready is only offered while waiting for a box
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready_r |-> state_r == S_IDLE)
    else $error("ready raised outside idle");

  // a result is only finished after the pipeline drained
  a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> stat.pipe_empty && stat.issue_done)
    else $error("finish with compares in flight");

  // a load always starts a scan
  a_load_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_SCAN)
    else $error("load did not start a scan");

endmodule

/* rtl/gbn_dp.sv */
// datapath: kept store, pipelined overlap test, counters and result register
module gbn_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gbn_pkg::gbn_cmd_t          cmd,
  output gbn_pkg::gbn_stat_t         stat,
  input  logic                       cfg_wr_en,
  input  logic [gbn_pkg::THR_W-1:0]  cfg_wr_data,
  input  logic                       in_start,
  input  gbn_pkg::gbn_box_t          in_box,
  input  logic                       out_tready,
  output logic                       out_tvalid,
  output logic                       out_keep,
  output logic [gbn_pkg::IDX_W-1:0]  out_index,
  output logic [gbn_pkg::KEPT_W-1:0] out_total,
  output logic                       out_overflow
);

  // configuration
  logic [gbn_pkg::THR_W-1:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= gbn_pkg::THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // current box, held for the whole scan
  gbn_pkg::gbn_box_t                cur_r;
  logic signed [gbn_pkg::EDGE_W-1:0] cur_right_r;
  logic signed [gbn_pkg::EDGE_W-1:0] cur_bottom_r;
  logic [gbn_pkg::AREA_W-1:0]        cur_area_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_r        <= in_box;
      cur_right_r  <= {in_box.left[gbn_pkg::COORD_W-1], in_box.left}
                      + $signed({2'b00, in_box.width});
      cur_bottom_r <= {in_box.top[gbn_pkg::COORD_W-1], in_box.top}
                      + $signed({2'b00, in_box.height});
      cur_area_r   <= in_box.width * in_box.height;
    end
  end

  // counters, read pointer and suppress flag
  logic [gbn_pkg::KEPT_W-1:0] kept_cnt_r;
  logic [gbn_pkg::KEPT_W-1:0] rd_ptr_r;
  logic [gbn_pkg::IDX_W-1:0]  box_cnt_r;
  logic [gbn_pkg::IDX_W-1:0]  idx_r;
  logic                       supp_r;
  logic                       hit;
  logic                       room;
  logic                       keep;

  assign room = kept_cnt_r < gbn_pkg::KEPT_W'(gbn_pkg::MAX_KEPT);
  assign keep = !supp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_cnt_r <= '0;
      box_cnt_r  <= '0;
      rd_ptr_r   <= '0;
      supp_r     <= 1'b0;
    end else begin
      if (cmd.load) begin
        rd_ptr_r <= '0;
        supp_r   <= 1'b0;
        if (in_start) begin
          kept_cnt_r <= '0;
          idx_r      <= '0;
          box_cnt_r  <= gbn_pkg::IDX_W'(1);
        end else begin
          idx_r <= box_cnt_r;
          if (box_cnt_r != '1) begin
            box_cnt_r <= box_cnt_r + gbn_pkg::IDX_W'(1);
          end
        end
      end
      if (cmd.issue) begin
        rd_ptr_r <= rd_ptr_r + gbn_pkg::KEPT_W'(1);
      end
      if (hit) begin
        supp_r <= 1'b1;
      end
      if (cmd.finish && keep && room) begin
        kept_cnt_r <= kept_cnt_r + gbn_pkg::KEPT_W'(1);
      end
    end
  end

  // kept store, one write and one registered read per cycle
  gbn_pkg::gbn_entry_t mem [gbn_pkg::MAX_KEPT];
  gbn_pkg::gbn_entry_t rd_q;

  always_ff @(posedge clk) begin
    if (cmd.finish && keep && room) begin
      mem[kept_cnt_r[gbn_pkg::ADDR_W-1:0]] <= '{box: cur_r, area: cur_area_r};
    end
    if (cmd.issue) begin
      rd_q <= mem[rd_ptr_r[gbn_pkg::ADDR_W-1:0]];
    end
  end

  // stage valids of the compare pipeline
  logic v0_r, va_r, vb_r, vc_r, vd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      v0_r <= cmd.issue;
      va_r <= v0_r;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  // stage a: overlap extents in each axis
  logic signed [gbn_pkg::EDGE_W-1:0]  k_right, k_bottom;
  logic signed [gbn_pkg::COORD_W-1:0] x0, y0;
  logic signed [gbn_pkg::EDGE_W-1:0]  x1, y1;
  logic signed [gbn_pkg::EDGE_W:0]    dx, dy;
  logic [gbn_pkg::DIM_W-1:0]          dx_r, dy_r;
  logic [gbn_pkg::AREA_W-1:0]         area_a_r;

  always_comb begin
    k_right  = {rd_q.box.left[gbn_pkg::COORD_W-1], rd_q.box.left}
               + $signed({2'b00, rd_q.box.width});
    k_bottom = {rd_q.box.top[gbn_pkg::COORD_W-1], rd_q.box.top}
               + $signed({2'b00, rd_q.box.height});
    x0 = (cur_r.left > rd_q.box.left) ? cur_r.left : rd_q.box.left;
    y0 = (cur_r.top > rd_q.box.top) ? cur_r.top : rd_q.box.top;
    x1 = (cur_right_r < k_right) ? cur_right_r : k_right;
    y1 = (cur_bottom_r < k_bottom) ? cur_bottom_r : k_bottom;
    dx = {x1[gbn_pkg::EDGE_W-1], x1} - {{2{x0[gbn_pkg::COORD_W-1]}}, x0};
    dy = {y1[gbn_pkg::EDGE_W-1], y1} - {{2{y0[gbn_pkg::COORD_W-1]}}, y0};
  end

  always_ff @(posedge clk) begin
    if (v0_r) begin
      // an empty overlap in either axis gives zero intersection
      if (dx > 0 && dy > 0) begin
        dx_r <= dx[gbn_pkg::DIM_W-1:0];
        dy_r <= dy[gbn_pkg::DIM_W-1:0];
      end else begin
        dx_r <= '0;
        dy_r <= '0;
      end
      area_a_r <= rd_q.area;
    end
  end

  // stage b: intersection area
  logic [gbn_pkg::AREA_W-1:0] inter_b_r, area_b_r;

  always_ff @(posedge clk) begin
    if (va_r) begin
      inter_b_r <= dx_r * dy_r;
      area_b_r  <= area_a_r;
    end
  end

  // stage c: union area
  logic [gbn_pkg::UNI_W-1:0]  uni_c_r;
  logic [gbn_pkg::AREA_W-1:0] inter_c_r;

  always_ff @(posedge clk) begin
    if (vb_r) begin
      uni_c_r   <= {1'b0, cur_area_r} + {1'b0, area_b_r} - {1'b0, inter_b_r};
      inter_c_r <= inter_b_r;
    end
  end

  // stage d: threshold times union
  logic [gbn_pkg::PROD_W-1:0] prod_d_r;
  logic [gbn_pkg::AREA_W-1:0] inter_d_r;
  logic                       uni_nz_d_r;

  always_ff @(posedge clk) begin
    if (vc_r) begin
      prod_d_r   <= thr_r * uni_c_r;
      inter_d_r  <= inter_c_r;
      uni_nz_d_r <= uni_c_r != '0;
    end
  end

  // stage e: suppression compare, an empty union never suppresses
  logic [gbn_pkg::PROD_W-1:0] inter_sh;

  assign inter_sh = gbn_pkg::PROD_W'({inter_d_r, {gbn_pkg::FRAC_SH{1'b0}}});
  assign hit      = vd_r && uni_nz_d_r && (inter_sh > prod_d_r);

  // result register, loaded once per box
  logic                       out_tvalid_r;
  logic                       out_keep_r;
  logic [gbn_pkg::IDX_W-1:0]  out_index_r;
  logic [gbn_pkg::KEPT_W-1:0] out_total_r;
  logic                       out_overflow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_keep_r     <= keep;
      out_index_r    <= idx_r;
      out_total_r    <= (keep && room) ? kept_cnt_r + gbn_pkg::KEPT_W'(1) : kept_cnt_r;
      out_overflow_r <= keep && !room;
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_keep     = out_keep_r;
  assign out_index    = out_index_r;
  assign out_total    = out_total_r;
  assign out_overflow = out_overflow_r;

  // status back to the controller
  assign stat.issue_done = rd_ptr_r == kept_cnt_r;
  assign stat.pipe_empty = !(v0_r || va_r || vb_r || vc_r || vd_r);
  assign stat.out_free   = !out_tvalid_r || out_tready;

  // the store count never passes its depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    kept_cnt_r <= gbn_pkg::KEPT_W'(gbn_pkg::MAX_KEPT))
    else $error("kept count beyond store depth");

  // reads never run past the stored entries
  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_ptr_r <= kept_cnt_r)
    else $error("read pointer past kept count");

  // overflow is only reported with a full store
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_overflow_r |->
      out_total_r == gbn_pkg::KEPT_W'(gbn_pkg::MAX_KEPT) && out_keep_r)
    else $error("overflow without full store");

  // a stored survivor advances the count by one
  a_store_inc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && keep && room |=> kept_cnt_r == $past(kept_cnt_r) + gbn_pkg::KEPT_W'(1))
    else $error("store did not advance count");

endmodule

/* rtl/greedy_box_nms_core.sv */
// top level of the greedy box non-maximum suppression core
// each box is compared with every kept box, up to 64 with a full store, and its result is
// registered once the compare pipeline has drained and the output register is free
// throughput: one box at a time, one kept box per compare cycle
// a new box is taken while the previous result still waits on the output register
// reset (rst_n low, synchronous) clears counts, box index and handshakes, threshold 115
module greedy_box_nms_core (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data,   // iou_threshold
  // input boxes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,      // box_left, box_top, box_width, box_height, zero pad
  input  logic        in_tuser,      // start_of_set
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata      // keep, box_index, kept_total, store_overflow, zero pad
);

  gbn_pkg::gbn_cmd_t  cmd;
  gbn_pkg::gbn_stat_t stat;
  gbn_pkg::gbn_box_t  in_box;

  logic                       out_keep;
  logic [gbn_pkg::IDX_W-1:0]  out_index;
  logic [gbn_pkg::KEPT_W-1:0] out_total;
  logic                       out_overflow;

  // unpack the box fields
  assign in_box.left   = $signed(in_tdata[15:0]);
  assign in_box.top    = $signed(in_tdata[31:16]);
  assign in_box.width  = in_tdata[46:32];
  assign in_box.height = in_tdata[61:47];

  gbn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gbn_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_start     (in_tuser),
    .in_box       (in_box),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .out_keep     (out_keep),
    .out_index    (out_index),
    .out_total    (out_total),
    .out_overflow (out_overflow)
  );

  // pack the result fields
  assign out_tdata = {7'b0, out_overflow, out_total, out_index, out_keep};

endmodule
